// File: rtl/core/face_curvature_error_indicator_defines.svh
// ----------------------------------------------------------------------------
// face_curvature_error_indicator_defines
// assertion macros for the face curvature error indicator
// ----------------------------------------------------------------------------
`ifndef FACE_CURVATURE_ERROR_INDICATOR_DEFINES_SVH
`define FACE_CURVATURE_ERROR_INDICATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FCEI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcei check failed");

// next-cycle implication checked on every clock edge outside reset
`define FCEI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcei check failed");

`endif

// File: rtl/core/fcei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcei_pkg
// shared types and command codes of the face curvature error indicator
// ----------------------------------------------------------------------------
package fcei_pkg;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_INTERNAL = 2'd1;
  localparam logic [1:0] CMD_BOUNDARY = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [11:0]        owner_cell;
    logic [11:0]        neighbour_cell;
    logic signed [31:0] x_owner;
    logic signed [31:0] x_neighbour;
    logic signed [31:0] x_face;
  } req_t;

  typedef struct packed {
    logic [16:0] indicator;
    logic [16:0] cell_error;
  } res_t;

  // work handed from the front to the back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] owner_cell;
    logic [11:0] neighbour_cell;
    logic [16:0] indicator;
  } job_t;

endpackage

// File: rtl/core/face_curvature_error_indicator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_curvature_error_indicator
// face second-difference indicator with per-cell maximum store
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. The front
// forms the magnitudes as it takes a face, then steps through the epsilon
// multiply, the denominator add, the long division and the integer root, and
// hands the job to the queue; a zero denominator skips division and root. Busy
// stays high until the hand-off, so the next request is taken only after it.
// A clear or read holds busy only for the hand-off. The back works each job on
// the store in steps (take with registered read, owner update, finish), with a
// neighbour update when an internal face has a distinct neighbour, and raises
// done_o on the cycle after the finish step. Clears and reads sent back to back
// outrun the back, so the two-entry queue fills and busy is held until it has
// room. Each request yields one result on res_o marked by done_o for one cycle;
// the receiver cannot stall, so results are never held. epsilon is taken only
// while busy and start are low. The store is not cleared at reset: a cell
// must be cleared before it is read or updated.
module face_curvature_error_indicator #(
  parameter int CELLS = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  fcei_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output fcei_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);

`include "face_curvature_error_indicator_defines.svh"

  logic [15:0]    epsilon_q;
  logic           fj_valid, fj_ready, bj_valid, bj_ready;
  fcei_pkg::job_t fj, bj;

  // epsilon register, written only while idle
  assign cfg_ready_o = !busy && !start;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epsilon_q <= 16'd655;
    end else if (cfg_valid_i && cfg_ready_o) begin
      epsilon_q <= cfg_data_i;
    end
  end

  fcei_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .epsilon_i(epsilon_q),
    .busy_o(busy), .job_valid_o(fj_valid), .job_o(fj), .job_ready_i(fj_ready)
  );

  fcei_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fj_valid), .wr_data_i(fj), .wr_ready_o(fj_ready),
    .rd_valid_o(bj_valid), .rd_data_o(bj), .rd_ready_i(bj_ready)
  );

  fcei_back #(.CELLS(CELLS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_valid), .job_i(bj), .job_ready_o(bj_ready),
    .done_o(done_o), .res_o
  );

  // clear and read never carry an indicator
  `FCEI_ASSERT_IMP(a_idle_zero, fj_valid && (fj.cmd == fcei_pkg::CMD_CLEAR ||
    fj.cmd == fcei_pkg::CMD_READ), fj.indicator == 17'd0)
  // indicator never exceeds one
  `FCEI_ASSERT_IMP(a_ind_range, fj_valid, fj.indicator <= 17'h10000)
  // a request is accepted only by an idle front
  `FCEI_ASSERT_NEXT(a_take_busy, start && !busy, busy)

endmodule

// File: rtl/core/fcei_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcei_front
// computes the face indicator: magnitudes, long division, integer root
// ----------------------------------------------------------------------------
module fcei_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fcei_pkg::req_t     req_i,
  input  logic [15:0]        epsilon_i,
  output logic               busy_o,
  output logic               job_valid_o,
  output fcei_pkg::job_t     job_o,
  input  logic               job_ready_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DEN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [11:0] own_q, own_d, nei_q, nei_d;
  logic [33:0] num_q, num_d;
  logic [34:0] diff_q, diff_d;
  logic [35:0] m_q, m_d;
  logic [51:0] prod_q, prod_d;
  logic [51:0] den_q, den_d;
  logic [52:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [33:0] sv_q, sv_d;
  logic [16:0] root_q, root_d;
  logic [17:0] srem_q, srem_d;
  logic [16:0] ind_q, ind_d;

  logic signed [33:0] xo, xn, xf, t_num, t_nf, t_fo;
  logic [33:0] a_nf, a_fo, a_n, a_f, a_o;
  logic [53:0] rsh;
  logic [19:0] trial;
  logic [17:0] srem_sh;

  always_comb begin
    xo    = 34'(req_i.x_owner);
    xn    = 34'(req_i.x_neighbour);
    xf    = 34'(req_i.x_face);
    t_num = xn - (xf <<< 1) + xo;
    t_nf  = xn - xf;
    t_fo  = xf - xo;
    a_nf  = t_nf[33] ? 34'(-t_nf) : 34'(t_nf);
    a_fo  = t_fo[33] ? 34'(-t_fo) : 34'(t_fo);
    a_n   = xn[33] ? 34'(-xn) : 34'(xn);
    a_f   = xf[33] ? 34'(-xf) : 34'(xf);
    a_o   = xo[33] ? 34'(-xo) : 34'(xo);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    own_d   = own_q;
    nei_d   = nei_q;
    num_d   = num_q;
    diff_d  = diff_q;
    m_d     = m_q;
    prod_d  = prod_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    sv_d    = sv_q;
    root_d  = root_q;
    srem_d  = srem_q;
    ind_d   = ind_q;
    rsh     = '0;
    srem_sh = '0;
    trial   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d  = req_i.cmd;
          own_d  = req_i.owner_cell;
          nei_d  = req_i.neighbour_cell;
          num_d  = t_num[33] ? 34'(-t_num) : 34'(t_num);
          diff_d = 35'(a_nf) + 35'(a_fo);
          m_d    = 36'(a_n) + 36'({a_f, 1'b0}) + 36'(a_o);
          ind_d  = '0;
          if (req_i.cmd == fcei_pkg::CMD_INTERNAL || req_i.cmd == fcei_pkg::CMD_BOUNDARY) begin
            state_d = S_MUL;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_MUL: begin
        prod_d  = 52'(m_q) * 52'(epsilon_i);
        state_d = S_DEN;
      end
      S_DEN: begin
        den_d   = {diff_q, 16'd0} + prod_q;
        rem_d   = 53'({num_q, 16'd0});
        quo_d   = '0;
        cnt_d   = 6'd0;
        state_d = ({diff_q, 16'd0} + prod_q == '0) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle, 33 bits
        rsh = (cnt_q == 6'd0) ? 54'(rem_q) : {rem_q, 1'b0};
        if (rsh >= 54'(den_q)) begin
          rem_d = 53'(rsh - 54'(den_q));
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          rem_d = 53'(rsh);
          quo_d = {quo_q[31:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          state_d = S_SQRT;
          cnt_d   = 6'd0;
          sv_d    = 34'(quo_d[32] && quo_d[31:0] != '0 ? 33'h1_0000_0000 : quo_d);
          root_d  = '0;
          srem_d  = '0;
        end
      end
      S_SQRT: begin
        // digit-by-digit root, two radicand bits a cycle, 17 steps
        srem_sh = 18'({srem_q[15:0], sv_q[33:32]});
        trial   = 20'({root_q[16:0], 2'b01});
        if (20'(srem_sh) >= trial) begin
          srem_d = 18'(20'(srem_sh) - trial);
          root_d = {root_q[15:0], 1'b1};
        end else begin
          srem_d = srem_sh;
          root_d = {root_q[15:0], 1'b0};
        end
        sv_d  = {sv_q[31:0], 2'b00};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd16) begin
          ind_d   = root_d;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (job_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    own_q  <= own_d;
    nei_q  <= nei_d;
    num_q  <= num_d;
    diff_q <= diff_d;
    m_q    <= m_d;
    prod_q <= prod_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    sv_q   <= sv_d;
    root_q <= root_d;
    srem_q <= srem_d;
    ind_q  <= ind_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign job_valid_o = (state_q == S_OUT);
  assign job_o       = '{cmd: cmd_q, owner_cell: own_q, neighbour_cell: nei_q,
                         indicator: ind_q};

endmodule

// File: rtl/core/fcei_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcei_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module fcei_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  fcei_pkg::job_t wr_data_i,
  output logic           wr_ready_o,
  output logic           rd_valid_o,
  output fcei_pkg::job_t rd_data_o,
  input  logic           rd_ready_i
);

  fcei_pkg::job_t slot_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = slot_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) slot_q[wp_q] <= wr_data_i;
  end

endmodule

// File: rtl/core/fcei_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcei_back
// per-cell maximum store: clear, max update of owner and neighbour, read
// ----------------------------------------------------------------------------
module fcei_back #(
  parameter int CELLS = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  fcei_pkg::job_t job_i,
  output logic           job_ready_o,
  output logic           done_o,
  output fcei_pkg::res_t res_o
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_OWN  = 2'd1;
  localparam logic [1:0] B_NEI  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [16:0]    mem [CELLS];
  logic [1:0]     state_q;
  fcei_pkg::job_t job_q;
  logic [16:0]    rd_q, own_val_q;
  logic           own_ok, nei_ok, is_face;
  logic [AW-1:0]  own_a, nei_a, rd_a;
  logic [16:0]    own_new, nei_new;
  logic           done_q;
  fcei_pkg::res_t res_q;

  assign own_ok  = 32'(job_q.owner_cell) < 32'(CELLS);
  assign nei_ok  = 32'(job_q.neighbour_cell) < 32'(CELLS);
  assign own_a   = AW'(job_q.owner_cell);
  assign nei_a   = AW'(job_q.neighbour_cell);
  assign is_face = job_q.cmd == fcei_pkg::CMD_INTERNAL ||
                   job_q.cmd == fcei_pkg::CMD_BOUNDARY;
  assign own_new = (job_q.cmd == fcei_pkg::CMD_CLEAR) ? 17'd0 :
                   (is_face && rd_q < job_q.indicator) ? job_q.indicator : rd_q;
  assign nei_new = (rd_q < job_q.indicator) ? job_q.indicator : rd_q;
  assign rd_a    = (state_q == B_IDLE) ? AW'(job_i.owner_cell) : nei_a;
  assign job_ready_o = (state_q == B_IDLE);

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_a];
    if (state_q == B_OWN && own_ok && job_q.cmd != fcei_pkg::CMD_READ)
      mem[own_a] <= own_new;
    else if (state_q == B_NEI && nei_ok)
      mem[nei_a] <= nei_new;
    if (state_q == B_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == B_OWN) own_val_q <= own_ok ? own_new : 17'd0;
    if (state_q == B_NEI && nei_ok && nei_a == own_a && own_ok) own_val_q <= nei_new;
    res_q <= '{indicator: job_q.indicator, cell_error: own_val_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == B_FIN);
      case (state_q)
        B_IDLE: if (job_valid_i) state_q <= B_OWN;
        B_OWN: begin
          // neighbour is read in the owner step and updated in its own step
          if (job_q.cmd == fcei_pkg::CMD_INTERNAL && !(job_q.neighbour_cell ==
              job_q.owner_cell)) state_q <= B_NEI;
          else state_q <= B_FIN;
        end
        B_NEI:  state_q <= B_FIN;
        B_FIN:  state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sim/face_curvature_error_indicator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_curvature_error_indicator_test
// self-checking bench for the face curvature error indicator
// ----------------------------------------------------------------------------
// A short table of directed requests is followed by three random phases at
// different epsilon values and sender idle rates. Every accepted request is
// run through a local model of the indicator and the per-cell maximum store.
// Every result on done_o is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module face_curvature_error_indicator_test;

  localparam int NCELLS = 4096;

  // one row of the directed table; known rows carry a typed-in result
  typedef struct packed {
    fcei_pkg::req_t rq;
    logic           known;
    logic [16:0]    ind;
    logic [16:0]    cell_err;
  } row_t;

  logic           clk_i, rst_ni;
  logic           start, busy, done_o;
  fcei_pkg::req_t req_i;
  fcei_pkg::res_t res_o;
  logic           cfg_valid_i, cfg_ready_o;
  logic [15:0]    cfg_data_i;

  face_curvature_error_indicator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done_o), .res_o(res_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // local copy of the block state
  logic [15:0] eps;
  logic [16:0] err_mem [NCELLS];
  logic        cleared [NCELLS];
  int          clear_list[$];

  fcei_pkg::res_t pending[$];
  int             n_fail, n_checked, n_faces, n_full;
  row_t           dir_tab[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // second-difference indicator, Q1.16
  function automatic logic [16:0] face_ind(logic signed [31:0] o, n, f);
    longint      d2, dn, dof;
    logic [63:0] num, dif, mag, den, rem, q, root, pw;
    d2  = longint'(n) - 2 * longint'(f) + longint'(o);
    dn  = longint'(n) - longint'(f);
    dof = longint'(f) - longint'(o);
    num = (d2 < 0) ? -d2 : d2;
    dif = ((dn < 0) ? -dn : dn) + ((dof < 0) ? -dof : dof);
    mag = ((n < 0) ? -longint'(n) : longint'(n)) + 2 * ((f < 0) ? -longint'(f) : longint'(f))
        + ((o < 0) ? -longint'(o) : longint'(o));
    den = (dif << 16) + 64'(eps) * mag;
    if (den == 0) return 17'd0;
    // restoring division: floor(num * 2^48 / den)
    rem = num << 16;
    q   = 0;
    if (rem >= den) begin
      rem = rem - den;
      q   = 1;
    end
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 1;
      end
    end
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    // integer square root
    root = 0;
    pw   = 64'd1 << 34;
    while (pw > q) pw = pw >> 2;
    while (pw != 0) begin
      if (q >= root + pw) begin
        q    = q - (root + pw);
        root = (root >> 1) + pw;
      end else begin
        root = root >> 1;
      end
      pw = pw >> 2;
    end
    return root[16:0];
  endfunction

  // advance the store model by one request and return the expected result
  function automatic fcei_pkg::res_t store_step(fcei_pkg::req_t rq);
    fcei_pkg::res_t r;
    r.indicator = '0;
    case (rq.cmd)
      fcei_pkg::CMD_CLEAR: begin
        err_mem[rq.owner_cell] = '0;
        if (!cleared[rq.owner_cell]) clear_list.push_back(rq.owner_cell);
        cleared[rq.owner_cell] = 1'b1;
      end
      fcei_pkg::CMD_INTERNAL, fcei_pkg::CMD_BOUNDARY: begin
        r.indicator = face_ind(rq.x_owner, rq.x_neighbour, rq.x_face);
        if (err_mem[rq.owner_cell] < r.indicator) err_mem[rq.owner_cell] = r.indicator;
        if (rq.cmd == fcei_pkg::CMD_INTERNAL && err_mem[rq.neighbour_cell] < r.indicator)
          err_mem[rq.neighbour_cell] = r.indicator;
      end
      default: ;
    endcase
    r.cell_error = err_mem[rq.owner_cell];
    return r;
  endfunction

  // present one request, hold it until taken, then log the prediction
  task automatic send_req(fcei_pkg::req_t rq, int idle_pct);
    fcei_pkg::res_t exp_r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    exp_r = store_step(rq);
    if (rq.cmd == fcei_pkg::CMD_INTERNAL || rq.cmd == fcei_pkg::CMD_BOUNDARY) n_faces++;
    if (exp_r.indicator == 17'h10000) n_full++;
    pending.push_back(exp_r);
  endtask

  // let everything drain, then some cycles for the store back end
  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    eps = v;
  endtask

  function automatic row_t mk(logic [1:0] c, logic [11:0] own, nei,
                              logic [31:0] xo, xn, xf,
                              logic known = 1'b0, logic [16:0] ind = '0,
                              logic [16:0] cell_err = '0);
    row_t r;
    r.rq       = '{cmd: c, owner_cell: own, neighbour_cell: nei,
                   x_owner: xo, x_neighbour: xn, x_face: xf};
    r.known    = known;
    r.ind      = ind;
    r.cell_err = cell_err;
    return r;
  endfunction

  // random request; faces and reads only touch cells already cleared
  function automatic fcei_pkg::req_t rand_req();
    fcei_pkg::req_t rq;
    int             sel;
    logic [31:0]    a;
    sel = $urandom_range(99);
    rq.cmd = (sel < 10) ? fcei_pkg::CMD_CLEAR : (sel < 20) ? fcei_pkg::CMD_READ :
             (sel < 62) ? fcei_pkg::CMD_INTERNAL : fcei_pkg::CMD_BOUNDARY;
    rq.owner_cell     = 12'(clear_list[$urandom_range(clear_list.size() - 1)]);
    rq.neighbour_cell = 12'(clear_list[$urandom_range(clear_list.size() - 1)]);
    if (rq.cmd == fcei_pkg::CMD_CLEAR) rq.owner_cell = 12'($urandom);
    // unused neighbour on boundary faces can be anything
    if (rq.cmd == fcei_pkg::CMD_BOUNDARY && $urandom_range(1))
      rq.neighbour_cell = 12'($urandom);
    case ($urandom_range(3))
      0: begin
        rq.x_owner = $urandom; rq.x_neighbour = $urandom; rq.x_face = $urandom;
      end
      1: begin
        // smooth field with small random curvature
        a = $urandom;
        rq.x_owner     = a + $urandom_range(4095) - 2048;
        rq.x_neighbour = a + $urandom_range(4095) - 2048;
        rq.x_face      = a + $urandom_range(255) - 128;
      end
      2: begin
        // sharp peak on the face
        a = $urandom_range(32'h00ffffff);
        rq.x_owner = a; rq.x_neighbour = a; rq.x_face = -a;
      end
      default: begin
        a = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        rq.x_owner     = $urandom_range(1) ? a : ~a;
        rq.x_neighbour = $urandom_range(1) ? a : $urandom;
        rq.x_face      = $urandom_range(1) ? ~a : 32'h0;
      end
    endcase
    return rq;
  endfunction

  // result checker; results cannot be held off, so check every done cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending.size() == 0) begin
        $error("unexpected result indicator=%h cell_error=%h",
               res_o.indicator, res_o.cell_error);
        n_fail++;
      end else begin
        if (res_o.indicator !== pending[0].indicator) begin
          $error("indicator expected %h actual %h", pending[0].indicator, res_o.indicator);
          n_fail++;
        end
        if (res_o.cell_error !== pending[0].cell_error) begin
          $error("cell_error expected %h actual %h", pending[0].cell_error, res_o.cell_error);
          n_fail++;
        end
        void'(pending.pop_front());
        n_checked++;
      end
    end
  end

  initial begin
    int             idle_pct [3] = '{36, 61, 0};
    logic [15:0]    eps_set [3];
    fcei_pkg::res_t got;
    row_t           rw;
    n_fail = 0; n_checked = 0; n_faces = 0; n_full = 0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    rst_ni      = 1'b0;
    eps = 16'd655;
    foreach (cleared[i]) begin
      cleared[i] = 1'b0;
      err_mem[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part, at the epsilon left by reset
    dir_tab.push_back(mk(fcei_pkg::CMD_CLEAR, 12'h000, 12'h000, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_CLEAR, 12'hfff, 12'hfff, '1, '1, '1, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_CLEAR, 12'haaa, 12'h555, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_CLEAR, 12'h555, 12'haaa, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_READ, 12'h000, 12'hfff, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_READ, 12'hfff, 12'h000, '1, '1, '1, 1, 0, 0));
    // zero denominator
    dir_tab.push_back(mk(fcei_pkg::CMD_INTERNAL, 12'h000, 12'hfff, 0, 0, 0, 1, 0, 0));
    // flat field, no curvature
    dir_tab.push_back(mk(fcei_pkg::CMD_INTERNAL, 12'h000, 12'hfff,
                         32'h10000, 32'h10000, 32'h10000, 1, 0, 0));
    // value extremes
    dir_tab.push_back(mk(fcei_pkg::CMD_INTERNAL, 12'haaa, 12'h555,
                         32'h7fffffff, 32'h80000000, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_INTERNAL, 12'haaa, 12'h555,
                         32'h7fffffff, 32'h7fffffff, 32'h80000000));
    dir_tab.push_back(mk(fcei_pkg::CMD_BOUNDARY, 12'hfff, 12'h123,
                         32'h10000, 0, 32'hffff0000));
    // owner and neighbour the same cell
    dir_tab.push_back(mk(fcei_pkg::CMD_INTERNAL, 12'h000, 12'h000,
                         32'h10000, 32'h10000, 32'hffff0000));
    dir_tab.push_back(mk(fcei_pkg::CMD_BOUNDARY, 12'h555, 12'h000,
                         32'h80000000, 32'h1, 32'h7fff0000));
    dir_tab.push_back(mk(fcei_pkg::CMD_READ, 12'haaa, 12'h000, 0, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_READ, 12'h555, 12'h000, 0, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_CLEAR, 12'haaa, 12'h000, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_READ, 12'haaa, 12'h000, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(fcei_pkg::CMD_READ, 12'hfff, 12'h000, 0, 0, 0));
    foreach (dir_tab[i]) begin
      rw = dir_tab[i];
      send_req(rw.rq, 0);
      // typed-in results override the model entry for their slot
      if (rw.known) begin
        got.indicator  = rw.ind;
        got.cell_error = rw.cell_err;
        pending[pending.size() - 1] = got;
      end
    end
    drain();

    // random phases: extremes of epsilon first, then a random weight
    eps_set[0] = 16'd0;
    eps_set[1] = 16'hffff;
    eps_set[2] = 16'($urandom);
    for (int ph = 0; ph < 3; ph++) begin
      write_eps(eps_set[ph]);
      for (int k = 0; k < 150; k++) begin
        // sender holds off until the pipe is empty once per phase
        if (k == 75) begin
          start <= 1'b0;
          while (pending.size() != 0) @(posedge clk_i);
        end
        send_req(rand_req(), idle_pct[ph]);
      end
      drain();
    end

    $display("covered %0d results, %0d faces, %0d at full scale, epsilon 655/0/ffff/%h",
             n_checked, n_faces, n_full, eps_set[2]);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
